// ===== hdl/fcsr_pkg.sv =====
`default_nettype none

package fcsr_pkg;

   localparam int CHANNELS = 4;
   localparam int DUTY_W = 7;
   localparam int TARGET_W = 8;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic ACTION_SET = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 7'd100;

   typedef struct packed {
      logic                       action;
      logic signed [TARGET_W-1:0] target_left_back;
      logic signed [TARGET_W-1:0] target_right_back;
      logic signed [TARGET_W-1:0] target_left_front;
      logic signed [TARGET_W-1:0] target_right_front;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_left_back;
      logic [DUTY_W-1:0] duty_right_back;
      logic [DUTY_W-1:0] duty_left_front;
      logic [DUTY_W-1:0] duty_right_front;
      logic              status;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      OUT_CURRENT,
      OUT_SUM,
      OUT_TARGET
   } out_src_type;

   typedef struct packed {
      logic                load_set;
      logic                scan;
      logic [CH_IDX_W-1:0] scan_idx;
      logic                div_step;
      logic                set_steps;
      logic                tick;
      logic                apply_targets;
      logic                out_load;
      out_src_type         out_src;
      logic                out_status;
      logic                out_last;
   } cmd_type;

   typedef struct packed {
      logic set_ok;
      logic steps_zero;
      logic steps_one;
      logic ramp_short;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/fcsr_datapath.sv =====
`default_nettype none

module fcsr_datapath #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [fcsr_pkg::DUTY_W-1:0]         csr_write_data,
   input  wire fcsr_pkg::req_type                   req_data,
   input  wire fcsr_pkg::cmd_type                   cmd,
   output fcsr_pkg::stat_type                       stat,
   output fcsr_pkg::rsp_type                        rsp_data
);

   localparam int CH = fcsr_pkg::CHANNELS;
   localparam int DW = fcsr_pkg::DUTY_W;
   localparam int LVL_W = DW + FRACTION_BITS;
   localparam int DIFF_W = LVL_W + 1;
   localparam int REM_W = LVL_W + 1;
   localparam int Q_W = FRACTION_BITS + 1;
   localparam int SUM_W = LVL_W + 1;
   localparam int STEPS_W = 8;

   logic [DW-1:0]      max_duty_ff;
   logic [LVL_W-1:0]   level_ff [CH];
   logic [DW-1:0]      target_ff [CH];
   logic [REM_W-1:0]   rem_ff [CH];
   logic [Q_W-1:0]     step_mag_ff [CH];
   logic               step_neg_ff [CH];
   logic [LVL_W-1:0]   max_ff;
   logic [STEPS_W-1:0] steps_ff;
   fcsr_pkg::rsp_type  rsp_ff;

   logic signed [fcsr_pkg::TARGET_W-1:0] tgt [CH];
   logic [CH-1:0]      tgt_ok;
   logic [DIFF_W-1:0]  diff [CH];
   logic [DIFF_W-1:0]  mag [CH];
   logic               div_ge [CH];
   logic [REM_W-1:0]   div_red [CH];
   logic [SUM_W-1:0]   sum_full [CH];
   logic [LVL_W-1:0]   sum [CH];
   logic [DW-1:0]      duty_sel [CH];
   logic [LVL_W-1:0]   scan_val;
   fcsr_pkg::rsp_type  rsp_in;

   always_comb begin
      tgt[0] = req_data.target_left_back;
      tgt[1] = req_data.target_right_back;
      tgt[2] = req_data.target_left_front;
      tgt[3] = req_data.target_right_front;
   end

   // validity, change and per-lane divider step
   always_comb begin
      for (int c = 0; c < CH; c++) begin
         tgt_ok[c] = !tgt[c][fcsr_pkg::TARGET_W-1] && (tgt[c][DW-1:0] <= max_duty_ff);
         diff[c] = {1'b0, tgt[c][DW-1:0], {FRACTION_BITS{1'b0}}} - {1'b0, level_ff[c]};
         mag[c] = diff[c][DIFF_W-1] ? (~diff[c] + 1'b1) : diff[c];
         div_ge[c] = rem_ff[c] >= {1'b0, max_ff};
         div_red[c] = div_ge[c] ? (rem_ff[c] - {1'b0, max_ff}) : rem_ff[c];
         if (step_neg_ff[c]) begin
            sum_full[c] = {1'b0, level_ff[c]} - {{(SUM_W-Q_W){1'b0}}, step_mag_ff[c]};
            sum[c] = sum_full[c][SUM_W-1] ? '0 : sum_full[c][LVL_W-1:0];
         end else begin
            sum_full[c] = {1'b0, level_ff[c]} + {{(SUM_W-Q_W){1'b0}}, step_mag_ff[c]};
            sum[c] = sum_full[c][LVL_W-1:0];
         end
      end
   end

   assign scan_val = rem_ff[cmd.scan_idx][LVL_W-1:0];

   assign stat.set_ok = &tgt_ok;
   assign stat.steps_zero = (steps_ff == '0);
   assign stat.steps_one = (steps_ff == STEPS_W'(1));
   assign stat.ramp_short = (max_ff[LVL_W-1:FRACTION_BITS] == '0);

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         case (cmd.out_src)
            fcsr_pkg::OUT_SUM:    duty_sel[c] = sum[c][LVL_W-1:FRACTION_BITS];
            fcsr_pkg::OUT_TARGET: duty_sel[c] = target_ff[c];
            default:              duty_sel[c] = level_ff[c][LVL_W-1:FRACTION_BITS];
         endcase
      end
      rsp_in.duty_left_back = duty_sel[0];
      rsp_in.duty_right_back = duty_sel[1];
      rsp_in.duty_left_front = duty_sel[2];
      rsp_in.duty_right_front = duty_sel[3];
      rsp_in.status = cmd.out_status;
      rsp_in.last = cmd.out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff <= fcsr_pkg::MAX_DUTY_RESET;
      end else if (csr_write_enable) begin
         max_duty_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         for (int c = 0; c < CH; c++) begin
            level_ff[c] <= '0;
            target_ff[c] <= '0;
         end
      end else begin
         if (cmd.set_steps) begin
            steps_ff <= {{(STEPS_W-DW){1'b0}}, max_ff[LVL_W-1:FRACTION_BITS]};
         end else if (cmd.tick) begin
            steps_ff <= steps_ff - 1'b1;
         end
         for (int c = 0; c < CH; c++) begin
            if (cmd.load_set) begin
               target_ff[c] <= tgt[c][DW-1:0];
            end
            if (cmd.apply_targets) begin
               level_ff[c] <= {target_ff[c], {FRACTION_BITS{1'b0}}};
            end else if (cmd.tick) begin
               level_ff[c] <= sum[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_set) begin
         max_ff <= '0;
      end else if (cmd.scan && (scan_val > max_ff)) begin
         max_ff <= scan_val;
      end
      for (int c = 0; c < CH; c++) begin
         if (cmd.load_set) begin
            rem_ff[c] <= mag[c][REM_W-1:0];
            step_neg_ff[c] <= diff[c][DIFF_W-1];
         end else if (cmd.div_step) begin
            rem_ff[c] <= {div_red[c][REM_W-2:0], 1'b0};
            step_mag_ff[c] <= {step_mag_ff[c][Q_W-2:0], div_ge[c]};
         end
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/fcsr_ctrl.sv =====
`default_nettype none

module fcsr_ctrl #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_action,
   input  wire logic               rsp_ready,
   input  wire fcsr_pkg::stat_type stat,
   output fcsr_pkg::cmd_type       cmd,
   output logic                    req_ready,
   output logic                    rsp_valid
);

   localparam int DCNT_W = $clog2(FRACTION_BITS + 1);
   localparam int IW = fcsr_pkg::CH_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DIVIDE,
      ST_LAST
   } state_type;

   state_type   state_ff, state_in;
   logic [IW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              accept;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      scan_cnt_in = scan_cnt_ff;
      div_cnt_in = div_cnt_ff;
      cmd = '0;
      cmd.out_src = fcsr_pkg::OUT_CURRENT;
      cmd.out_status = fcsr_pkg::STATUS_OK;
      cmd.scan_idx = scan_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == fcsr_pkg::ACTION_SET) begin
                  if (stat.set_ok) begin
                     cmd.load_set = 1'b1;
                     scan_cnt_in = '0;
                     state_in = ST_SCAN;
                  end else begin
                     cmd.out_load = 1'b1;
                     cmd.out_status = fcsr_pkg::STATUS_REJECT;
                  end
               end else if (!stat.steps_zero) begin
                  cmd.tick = 1'b1;
                  cmd.out_load = 1'b1;
                  cmd.out_src = fcsr_pkg::OUT_SUM;
                  if (stat.steps_one) begin
                     state_in = ST_LAST;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IW'(fcsr_pkg::CHANNELS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.set_steps = 1'b1;
            cmd.out_load = 1'b1;
            if (stat.ramp_short) begin
               cmd.apply_targets = 1'b1;
               cmd.out_src = fcsr_pkg::OUT_TARGET;
               cmd.out_last = 1'b1;
               state_in = ST_IDLE;
            end else begin
               div_cnt_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCNT_W'(FRACTION_BITS)) begin
               state_in = ST_IDLE;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               cmd.apply_targets = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_src = fcsr_pkg::OUT_TARGET;
               cmd.out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_cnt_ff <= '0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/four_channel_speed_ramp_core.sv =====
// Four-channel linear duty ramp. A set beat with four in-range targets
// restarts the ramp from the present duties: the largest change sets the
// step count, and each channel gets its own Q1.FRACTION_BITS increment.
// Each tick beat then advances one step and returns the truncated duties;
// the last step returns a second beat with the exact targets and last set.
// Out-of-range targets return one beat with status set and change nothing;
// a tick with no ramp under way returns nothing. A set beat holds the input
// closed while it is taken, each channel is scanned in turn for the
// largest change, the step count is decided, and the per-channel restoring
// dividers, retiring one quotient bit per cycle, form the increments; a
// change under one duty step applies and returns the targets at once.
// The target beat that ends a ramp waits for the output register. A new
// beat is taken only while the output register is empty or being emptied.
`default_nettype none

module four_channel_speed_ramp_core #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire fcsr_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output fcsr_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_write_enable,
   input  wire logic [fcsr_pkg::DUTY_W-1:0] csr_write_data
);

   fcsr_pkg::cmd_type  cmd;
   fcsr_pkg::stat_type stat;

   fcsr_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid)
   );

   fcsr_datapath #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_data         (rsp_data)
   );

`ifndef SYNTH
   // a beat is taken only when the output register can take its result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
      else $error("input beat taken while output register is blocked");

   // the final target beat of a ramp never carries a reject
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.status == fcsr_pkg::STATUS_OK))
      else $error("last beat carries reject status");

   // a good set keeps the input closed on the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.action == fcsr_pkg::ACTION_SET)
       && !$past(reset)) |=> (!req_ready || rsp_valid))
      else $error("input reopened right after a set beat");
`endif

endmodule

`default_nettype wire
